/* src/hex_frame_encoder_core_defines.svh */
// Assertion macros of the checker of the hex frame encoder.
// Depends on nothing; included by the files that assert.
`ifndef HEX_FRAME_ENCODER_CORE_DEFINES_SVH
`define HEX_FRAME_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define HFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/hfe_pkg.sv */
// Types, constants and the microcode table of the hex frame encoder.
// Depends on nothing; imported by the core, its checker and the testbench.
package hfe_pkg;

    localparam int STEP_W = 5;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_A       = 8'h41;

    typedef enum logic [1:0] {
        REG_GET_CODE      = 2'd0,
        REG_SET_CODE      = 2'd1,
        REG_CHECKSUM_BASE = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_U8  = 3'd0,
        KIND_U16 = 3'd1,
        KIND_U32 = 3'd2,
        KIND_S16 = 3'd3,
        KIND_S32 = 3'd4
    } value_kind_t;

    // Character source of one microcode step.
    typedef enum logic [2:0] {
        SEL_COLON,
        SEL_HI,
        SEL_LO,
        SEL_CS_HI,
        SEL_CS_LO,
        SEL_NEWLINE
    } char_sel_t;

    // Byte of the latched request that a step looks at.
    typedef enum logic [2:0] {
        BYTE_CMD,
        BYTE_REG_LO,
        BYTE_REG_HI,
        BYTE_ZERO,
        BYTE_VAL0,
        BYTE_VAL1,
        BYTE_VAL2,
        BYTE_VAL3
    } byte_sel_t;

    // Jump conditions, tested when the step is issued.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NOT_GETSET,
        COND_NO_VALUE,
        COND_KIND_U8,
        COND_KIND_U16
    } cond_t;

    typedef struct packed {
        char_sel_t         sel;
        byte_sel_t         bsel;
        logic              acc;
        logic              last;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    localparam logic [STEP_W-1:0] STEP_CS = 5'd16;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{SEL_NEWLINE, BYTE_ZERO, 1'b0, 1'b1, COND_NEVER, '0};
        unique case (step)
            5'd0:  w = '{SEL_COLON,   BYTE_ZERO,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd1:  w = '{SEL_LO,      BYTE_CMD,    1'b1, 1'b0, COND_NOT_GETSET, STEP_CS};
            5'd2:  w = '{SEL_HI,      BYTE_REG_LO, 1'b0, 1'b0, COND_NEVER,      '0};
            5'd3:  w = '{SEL_LO,      BYTE_REG_LO, 1'b1, 1'b0, COND_NEVER,      '0};
            5'd4:  w = '{SEL_HI,      BYTE_REG_HI, 1'b0, 1'b0, COND_NEVER,      '0};
            5'd5:  w = '{SEL_LO,      BYTE_REG_HI, 1'b1, 1'b0, COND_NEVER,      '0};
            5'd6:  w = '{SEL_HI,      BYTE_ZERO,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd7:  w = '{SEL_LO,      BYTE_ZERO,   1'b1, 1'b0, COND_NO_VALUE,   STEP_CS};
            5'd8:  w = '{SEL_HI,      BYTE_VAL0,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd9:  w = '{SEL_LO,      BYTE_VAL0,   1'b1, 1'b0, COND_KIND_U8,    STEP_CS};
            5'd10: w = '{SEL_HI,      BYTE_VAL1,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd11: w = '{SEL_LO,      BYTE_VAL1,   1'b1, 1'b0, COND_KIND_U16,   STEP_CS};
            5'd12: w = '{SEL_HI,      BYTE_VAL2,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd13: w = '{SEL_LO,      BYTE_VAL2,   1'b1, 1'b0, COND_NEVER,      '0};
            5'd14: w = '{SEL_HI,      BYTE_VAL3,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd15: w = '{SEL_LO,      BYTE_VAL3,   1'b1, 1'b0, COND_NEVER,      '0};
            5'd16: w = '{SEL_CS_HI,   BYTE_ZERO,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd17: w = '{SEL_CS_LO,   BYTE_ZERO,   1'b0, 1'b0, COND_NEVER,      '0};
            5'd18: w = '{SEL_NEWLINE, BYTE_ZERO,   1'b0, 1'b1, COND_NEVER,      '0};
            default: w = '{SEL_NEWLINE, BYTE_ZERO, 1'b0, 1'b1, COND_NEVER,      '0};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib <= 4'd9)
        begin
            c = CHAR_ZERO + {4'd0, nib};
        end
        else
        begin
            c = CHAR_A + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

/* src/hfe_if.sv */
// Valid/ready channel interfaces of the hex frame encoder: request and character.
// Depends on nothing.
interface hfe_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [15:0] register_id;
    logic [31:0] data_value;
    logic [2:0]  value_kind;

    modport source (output valid, command, register_id, data_value, value_kind,
                    input ready);
    modport sink (input valid, command, register_id, data_value, value_kind,
                  output ready);
endinterface

interface hfe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_char;
    logic       last_char;

    modport source (output valid, frame_char, last_char, input ready);
    modport sink (input valid, frame_char, last_char, output ready);
endinterface

/* src/hex_frame_encoder_core.sv */
// Hex frame encoder: microcoded sequencer that turns a request into ASCII characters.
// Depends on hfe_pkg and the channel interfaces in hfe_if.sv.
//
// Usage: a request (command, register_id, data_value, value_kind) is taken on the
// req channel; the frame comes out on the chars channel one character per
// transfer, ':' first and a newline with last_char set at the end. A frame has 5,
// 11, 13, 15 or 19 characters depending on the command and value kind.
// The request is taken while no frame is in progress. Its transfer sets the busy
// flag, the first character then goes into the output register, and one
// character leaves per cycle while the receiver keeps ready high; the next
// request is taken only once the newline of the frame has been issued. The rate
// is set by the step counter, which issues one control word per cycle unless the
// receiver stalls; then the character in the output register holds and the step
// counter waits. Configuration (get code, set code, checksum base) is written
// through cfg_we/cfg_index/cfg_wdata while the block is idle: the user must keep
// to this, the block leaves it unchecked. Reset returns the codes to 7 and 8 and
// the base to 85, clears the sequencer and empties the output register.
module hex_frame_encoder_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  hfe_pkg::cfg_index_t       cfg_index,
    input  logic [7:0]                cfg_wdata,
    hfe_req_if.sink                   req,
    hfe_char_if.source                chars
);
    import hfe_pkg::*;

    logic [3:0]        get_code_reg;
    logic [3:0]        set_code_reg;
    logic [7:0]        base_reg;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [7:0]        cs_reg;
    logic [3:0]        cmd_reg;
    logic [15:0]       regid_reg;
    logic [31:0]       val_reg;
    logic [2:0]        kind_reg;

    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              out_last_reg;

    ucode_t            uw;
    logic [7:0]        cur_byte;
    logic [7:0]        cur_char;
    logic              is_set;
    logic              jump;
    logic              issue;
    logic              in_fire;

    assign req.ready = !busy_reg;
    assign in_fire   = req.valid && !busy_reg;
    assign issue     = busy_reg && (!out_valid_reg || chars.ready);

    assign uw     = ucode_rom(step_reg);
    assign is_set = (cmd_reg == set_code_reg);

    always_comb
    begin
        unique case (uw.bsel)
            BYTE_CMD:    cur_byte = {4'd0, cmd_reg};
            BYTE_REG_LO: cur_byte = regid_reg[7:0];
            BYTE_REG_HI: cur_byte = regid_reg[15:8];
            BYTE_ZERO:   cur_byte = 8'd0;
            BYTE_VAL0:   cur_byte = val_reg[7:0];
            BYTE_VAL1:   cur_byte = val_reg[15:8];
            BYTE_VAL2:   cur_byte = val_reg[23:16];
            BYTE_VAL3:   cur_byte = val_reg[31:24];
            default:     cur_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        unique case (uw.sel)
            SEL_COLON:   cur_char = CHAR_COLON;
            SEL_HI:      cur_char = hex_char(cur_byte[7:4]);
            SEL_LO:      cur_char = hex_char(cur_byte[3:0]);
            SEL_CS_HI:   cur_char = hex_char(cs_reg[7:4]);
            SEL_CS_LO:   cur_char = hex_char(cs_reg[3:0]);
            SEL_NEWLINE: cur_char = CHAR_NEWLINE;
            default:     cur_char = CHAR_NEWLINE;
        endcase
    end

    // Unused kinds beyond u32 send no value bytes, like the signed kinds.
    always_comb
    begin
        unique case (uw.cond)
            COND_NEVER:      jump = 1'b0;
            COND_NOT_GETSET: jump = (cmd_reg != get_code_reg) && !is_set;
            COND_NO_VALUE:   jump = !is_set || (kind_reg > KIND_U32);
            COND_KIND_U8:    jump = (kind_reg == KIND_U8);
            COND_KIND_U16:   jump = (kind_reg == KIND_U16);
            default:         jump = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            get_code_reg <= 4'd7;
            set_code_reg <= 4'd8;
            base_reg     <= 8'd85;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GET_CODE:      get_code_reg <= cfg_wdata[3:0];
                REG_SET_CODE:      set_code_reg <= cfg_wdata[3:0];
                REG_CHECKSUM_BASE: base_reg     <= cfg_wdata;
                REG_UNUSED:        ;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (issue)
            begin
                if (uw.last)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= jump ? uw.target : step_reg + 1'b1;
            end

            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chars.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= req.command;
            regid_reg <= req.register_id;
            val_reg   <= req.data_value;
            kind_reg  <= req.value_kind;
            cs_reg    <= base_reg - {4'd0, req.command};
        end
        else if (issue && uw.acc && (uw.bsel != BYTE_CMD))
        begin
            cs_reg <= cs_reg - cur_byte;
        end

        if (issue)
        begin
            out_char_reg <= cur_char;
            out_last_reg <= uw.last;
        end
    end

    assign chars.valid      = out_valid_reg;
    assign chars.frame_char = out_char_reg;
    assign chars.last_char  = out_last_reg;

endmodule

/* src/hfe_checker.sv */
// Port-level checker of the hex frame encoder, bound to the core.
// Depends on hfe_pkg and the macros in hex_frame_encoder_core_defines.svh.
`include "hex_frame_encoder_core_defines.svh"

module hfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] frame_char,
    input logic       last_char
);
    import hfe_pkg::*;

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // A stalled character keeps its value.
    `HFE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_stall,
        out_valid && $stable(frame_char) && $stable(last_char))
    // A new request is not taken while a frame is being sent.
    `HFE_ASSERT_NEXT(a_no_overlap, clk, rst_n, in_xfer, !in_ready)
    // The frame ends only on a newline.
    `HFE_ASSERT_IMPL(a_last_newline, clk, rst_n, out_valid && last_char,
        frame_char == CHAR_NEWLINE)
    // While a non-final character waits, the frame is still in progress.
    `HFE_ASSERT_IMPL(a_mid_frame_busy, clk, rst_n, out_valid && !last_char, !in_ready)
    // Right after a request transfer the output register is empty or still holds
    // the newline of the previous frame.
    `HFE_ASSERT_NEXT(a_req_out_clear, clk, rst_n, in_xfer, !out_valid || last_char)

endmodule

bind hex_frame_encoder_core hfe_checker u_hfe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (chars.valid),
    .out_ready  (chars.ready),
    .frame_char (chars.frame_char),
    .last_char  (chars.last_char)
);

/* test/testbench.sv */
// Self-checking testbench for hex_frame_encoder_core: random and directed requests with
// random stalls on both channels, each character checked against a predicted frame.
// Depends on hfe_pkg, the channel interfaces in hfe_if.sv and the core itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hfe_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int LIMIT_CYCLES    = 500000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;

    localparam logic [3:0] DEFAULT_GET_CODE = 4'd7;
    localparam logic [3:0] DEFAULT_SET_CODE = 4'd8;
    localparam logic [7:0] DEFAULT_BASE     = 8'd85;

    typedef struct packed {
        logic [3:0]  command;
        logic [15:0] register_id;
        logic [31:0] data_value;
        logic [2:0]  value_kind;
    } request_t;

    typedef struct packed {
        logic [7:0] frame_char;
        logic       last_char;
    } frame_char_t;

    // Holds a copy of the configuration and the characters still owed by the block.
    class frame_scoreboard;
        logic [3:0]  get_code;
        logic [3:0]  set_code;
        logic [7:0]  checksum_base;
        logic [7:0]  frame_sum;
        frame_char_t pending_chars[$];
        int          errors;
        int          frames_seen;
        int          chars_checked;
        int          requests_seen;

        function new();
            get_code      = DEFAULT_GET_CODE;
            set_code      = DEFAULT_SET_CODE;
            checksum_base = DEFAULT_BASE;
            errors        = 0;
            frames_seen   = 0;
            chars_checked = 0;
            requests_seen = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [7:0] value);
            case (idx)
                REG_GET_CODE:      get_code = value[3:0];
                REG_SET_CODE:      set_code = value[3:0];
                REG_CHECKSUM_BASE: checksum_base = value;
                default:           ;
            endcase
        endfunction

        function logic [7:0] ascii_nibble(logic [3:0] n);
            if (n < 4'd10)
            begin
                return 8'd48 + {4'd0, n};
            end
            return 8'd55 + {4'd0, n};
        endfunction

        function void push_char(logic [7:0] c, logic last);
            frame_char_t fc;
            fc.frame_char = c;
            fc.last_char  = last;
            pending_chars.push_back(fc);
        endfunction

        function void push_byte(logic [7:0] b);
            push_char(ascii_nibble(b[7:4]), 1'b0);
            push_char(ascii_nibble(b[3:0]), 1'b0);
            frame_sum = frame_sum - b;
        endfunction

        function void note_request(request_t r);
            int value_bytes;
            requests_seen++;
            frame_sum = checksum_base - {4'd0, r.command};
            push_char(CHAR_COLON, 1'b0);
            push_char(ascii_nibble(r.command), 1'b0);
            if (r.command == get_code || r.command == set_code)
            begin
                push_byte(r.register_id[7:0]);
                push_byte(r.register_id[15:8]);
                push_byte(8'h00);
                if (r.command == set_code)
                begin
                    case (r.value_kind)
                        KIND_U8:  value_bytes = 1;
                        KIND_U16: value_bytes = 2;
                        KIND_U32: value_bytes = 4;
                        default:  value_bytes = 0;
                    endcase
                    for (int i = 0; i < value_bytes; i++)
                    begin
                        push_byte(r.data_value[8*i +: 8]);
                    end
                end
            end
            push_char(ascii_nibble(frame_sum[7:4]), 1'b0);
            push_char(ascii_nibble(frame_sum[3:0]), 1'b0);
            push_char(CHAR_NEWLINE, 1'b1);
        endfunction

        function void check_char(frame_char_t got);
            frame_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, actual %h last %b",
                         $time, got.frame_char, got.last_char);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            chars_checked++;
            if (got.last_char)
            begin
                frames_seen++;
            end
            if (got.frame_char !== want.frame_char)
            begin
                $display("%0t: frame_char mismatch, expected %h, actual %h",
                         $time, want.frame_char, got.frame_char);
                errors++;
            end
            if (got.last_char !== want.last_char)
            begin
                $display("%0t: last_char mismatch, expected %b, actual %b",
                         $time, want.last_char, got.last_char);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    logic [7:0] cfg_wdata;

    hfe_req_if  req_ch();
    hfe_char_if char_ch();

    hex_frame_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .chars     (char_ch)
    );

    frame_scoreboard sb = new();

    int cycle_count  = 0;
    int hold_request = 0;
    int settings_run = 0;
    bit steady       = 1'b0;
    bit held_once    = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            r.command = sb.get_code;
        end
        else if (pick < 8)
        begin
            r.command = sb.set_code;
        end
        else
        begin
            r.command = 4'($urandom_range(0, 15));
        end
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            r.register_id = 16'h0000;
        end
        else if (pick == 1)
        begin
            r.register_id = 16'hFFFF;
        end
        else
        begin
            r.register_id = 16'($urandom);
        end
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            r.data_value = 32'h0000_0000;
        end
        else if (pick == 1)
        begin
            r.data_value = 32'hFFFF_FFFF;
        end
        else
        begin
            r.data_value = $urandom;
        end
        if ($urandom_range(0, 99) < 85)
        begin
            r.value_kind = 3'($urandom_range(0, 4));
        end
        else
        begin
            r.value_kind = 3'($urandom_range(5, 7));
        end
        return r;
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= r.command;
        req_ch.register_id <= r.register_id;
        req_ch.data_value  <= r.data_value;
        req_ch.value_kind  <= r.value_kind;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    // The request of the last transfer may not be noted yet when this task starts, so look after an edge first.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending_chars.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes every register in turn, the unused index included.
    task automatic program_config(logic [3:0] get_code, logic [3:0] set_code,
                                  logic [7:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GET_CODE;
        cfg_wdata <= {4'($urandom_range(0, 15)), get_code};
        @(posedge clk);
        cfg_index <= REG_SET_CODE;
        cfg_wdata <= {4'($urandom_range(0, 15)), set_code};
        @(posedge clk);
        cfg_index <= REG_CHECKSUM_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 8'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(REG_GET_CODE, {4'd0, get_code});
        sb.set_register(REG_SET_CODE, {4'd0, set_code});
        sb.set_register(REG_CHECKSUM_BASE, base);
        settings_run++;
    endtask

    // Receiver: random runs of ready with stalls, a steady mode and a counted long hold.
    initial
    begin
        int run_len;
        int stall;
        int hold;
        char_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                hold = hold_request;
                hold_request = 0;
                char_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
                held_once = 1'b1;
            end
            else if (steady)
            begin
                char_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run_len = $urandom_range(1, 24);
                char_ch.ready <= 1'b1;
                repeat (run_len) @(posedge clk);
                stall = idle_gap();
                if (stall > 0)
                begin
                    char_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        request_t    r;
        frame_char_t c;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                r.command     = req_ch.command;
                r.register_id = req_ch.register_id;
                r.data_value  = req_ch.data_value;
                r.value_kind  = req_ch.value_kind;
                sb.note_request(r);
            end
            if (char_ch.valid && char_ch.ready)
            begin
                c.frame_char = char_ch.frame_char;
                c.last_char  = char_ch.last_char;
                sb.check_char(c);
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d characters still expected",
                 $time, cycle_count, sb.pending_chars.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [3:0] code_a;
        logic [3:0] code_b;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_GET_CODE;
        cfg_wdata          <= 8'h00;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= 4'h0;
        req_ch.register_id <= 16'h0000;
        req_ch.data_value  <= 32'h0000_0000;
        req_ch.value_kind  <= KIND_U8;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under the reset configuration.
        send_request('{DEFAULT_GET_CODE, 16'h0000, 32'h0000_0000, KIND_U8});
        send_request('{DEFAULT_GET_CODE, 16'hFFFF, 32'hFFFF_FFFF, KIND_U32});
        send_request('{DEFAULT_GET_CODE, 16'hA55A, 32'h1234_5678, KIND_S16});
        send_request('{DEFAULT_SET_CODE, 16'h0001, 32'hFFFF_FFFF, KIND_U8});
        send_request('{DEFAULT_SET_CODE, 16'h8000, 32'hFFFF_FFFF, KIND_U16});
        send_request('{DEFAULT_SET_CODE, 16'hFFFF, 32'hFFFF_FFFF, KIND_U32});
        send_request('{DEFAULT_SET_CODE, 16'h1234, 32'h0000_0000, KIND_U32});
        send_request('{DEFAULT_SET_CODE, 16'h00FF, 32'h89AB_CDEF, KIND_S16});
        send_request('{DEFAULT_SET_CODE, 16'hFF00, 32'h89AB_CDEF, KIND_S32});
        // Value kinds beyond the signed ones send no value bytes.
        send_request('{DEFAULT_SET_CODE, 16'h5A5A, 32'hDEAD_BEEF, 3'd5});
        send_request('{DEFAULT_SET_CODE, 16'hA5A5, 32'hDEAD_BEEF, 3'd6});
        send_request('{DEFAULT_SET_CODE, 16'h0F0F, 32'hDEAD_BEEF, 3'd7});
        send_request('{4'h0, 16'hFFFF, 32'hFFFF_FFFF, KIND_U32});
        send_request('{4'hF, 16'hFFFF, 32'hFFFF_FFFF, KIND_U32});
        send_request('{4'h9, 16'h1234, 32'h5678_9ABC, KIND_U16});
        wait_for_drain();

        // Get and set share one code, so the frame carries the value.
        program_config(4'hF, 4'hF, 8'h00);
        send_request('{4'hF, 16'hBEEF, 32'hCAFE_F00D, KIND_U8});
        send_request('{4'hF, 16'h0000, 32'hFFFF_FFFF, KIND_U32});
        send_request('{4'h0, 16'hFFFF, 32'hFFFF_FFFF, KIND_U16});
        wait_for_drain();

        program_config(4'h0, 4'hF, 8'hFF);
        send_request('{4'h0, 16'hFFFF, 32'hFFFF_FFFF, KIND_U32});
        send_request('{4'hF, 16'hFFFF, 32'hFFFF_FFFF, KIND_U32});
        send_request('{4'hF, 16'h0000, 32'h0000_0000, KIND_U16});
        send_request('{DEFAULT_GET_CODE, 16'h1111, 32'h2222_2222, KIND_U32});
        wait_for_drain();

        // Random phases, each under its own configuration.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            code_a = 4'($urandom_range(0, 15));
            code_b = 4'($urandom_range(0, 15));
            case (phase)
                0:       program_config(DEFAULT_GET_CODE, DEFAULT_SET_CODE, DEFAULT_BASE);
                1:       program_config(4'h0, 4'hF, 8'h00);
                2:       program_config(code_a, code_a, 8'hFF);
                default: program_config(code_a, code_b, 8'($urandom));
            endcase
            steady = (phase == 3);
            if (phase == 5)
            begin
                hold_request = HOLD_CYCLES;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_request(random_request());
            end
            wait_for_drain();
            steady = 1'b0;
        end

        $display("Checked %0d frames, %0d characters, from %0d requests under %0d settings.",
                 sb.frames_seen, sb.chars_checked, sb.requests_seen, settings_run + 1);
        $display("Run included a back-to-back phase and a long receiver hold (done: %0b).",
                 held_once);
        if (sb.errors == 0 && sb.pending_chars.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d errors, %0d characters never arrived",
                     sb.errors, sb.pending_chars.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* hex_frame_encoder_core.f */
+incdir+src
src/hfe_pkg.sv
src/hfe_if.sv
src/hex_frame_encoder_core.sv
src/hfe_checker.sv
test/testbench.sv
